@@ sv/tev_pkg.sv @@
// ---------------------------------------------------------------------------
// tev_pkg: shared constants and helpers for the triggered envelope VCA
// Mode codes, register addresses and Q31 saturation.
// ---------------------------------------------------------------------------
package tev_pkg;

    localparam logic [31:0] Q31_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q31_MIN = 32'h8000_0000;

    localparam int unsigned ADDR_W = 4;

    localparam logic [ADDR_W-1:0] ADDR_MODE  = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_DECAY = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_GAIN  = 4'h8;

    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_PULSE = 3'd1;
    localparam logic [2:0] MODE_LIN   = 3'd2;
    localparam logic [2:0] MODE_EXP   = 3'd3;
    localparam logic [2:0] MODE_INV   = 3'd4;
    localparam logic [2:0] MODE_TRI   = 3'd5;
    localparam logic [2:0] MODE_LEVEL = 3'd6;
    localparam logic [2:0] MODE_OFF2  = 3'd7;

    function automatic logic [33:0] sext34(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    // saturate a 34-bit signed value to Q31
    function automatic logic [31:0] sat_q31(input logic [33:0] v);
        logic [31:0] r;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111))
            r = v[31:0];
        else if (v[33])
            r = Q31_MIN;
        else
            r = Q31_MAX;
        return r;
    endfunction

endpackage

@@ sv/triggered_envelope_vca.sv @@
// ---------------------------------------------------------------------------
// triggered_envelope_vca: triggered envelope generator and VCA
// Per sample, by mode: latch trigger, update phase and envelope, scale the input or output a fixed value.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tdata carries sample_in (Q31), s_axis_tuser the
//   trigger bit. One transfer per audio sample.
//   Output stream: m_axis_tdata carries sample_out (Q31), one transfer per
//   input transfer, in order.
//   APB port: mode at 0x0, decay_rate at 0x4, level_gain at 0x8; write only
//   while no sample is in flight.
//   Off, pulse and trigger samples bypass the multiplier; level and linear
//   samples take one pass of the bit-serial multiplier for the output
//   scaling; the exponential, inverted ramp and triangle envelopes take
//   one more pass to compute the envelope.
//   One sample is in process at a time; the next input transfer is taken
//   once the current result has moved to the output register. A new
//   sample is taken while the previous result still waits in the output
//   register.
//   A stalled receiver holds the output register; once a second result is
//   ready the block waits and stops taking input.
//   Reset clears phase, envelope and pending trigger, selects mode off,
//   zero decay rate and full-scale level gain.
// ---------------------------------------------------------------------------
module triggered_envelope_vca (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,   // [31:0] sample_in
    input  logic                     s_axis_tuser,   // [0] trigger
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,   // [31:0] sample_out
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [tev_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import tev_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MENV = 6'b000100,
        S_EUPD = 6'b001000,
        S_MOUT = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t      st_reg, st_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] env_reg, env_next;
    logic        pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [2:0]  mode_reg;
    logic [31:0] rate_reg;
    logic [31:0] gain_reg;

    logic        mul_start;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_busy;
    logic        mul_done;
    logic [31:0] mul_prod;

    logic [31:0] lin_env;
    logic [31:0] neg_phase;
    logic [31:0] env_new;
    logic        cfg_wr;
    logic        in_xfer;

    tev_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr)
            ADDR_MODE:  prdata = {29'd0, mode_reg};
            ADDR_DECAY: prdata = rate_reg;
            ADDR_GAIN:  prdata = gain_reg;
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
            rate_reg <= 32'd0;
            gain_reg <= Q31_MAX;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_MODE)
                mode_reg <= pwdata[2:0];
            if (paddr == ADDR_DECAY)
                rate_reg <= pwdata;
            if (paddr == ADDR_GAIN)
                gain_reg <= pwdata;
        end
    end

    assign lin_env   = sat_q31(sext34(Q31_MAX) - sext34(phase_reg));
    assign neg_phase = sat_q31(34'd0 - sext34(phase_reg));

    always_comb
    begin
        case (mode_reg) inside
            MODE_EXP: env_new = mul_prod;
            MODE_INV: env_new = sat_q31(sext34(env_reg) + sext34(mul_prod));
            default:  env_new = mul_prod[31] ? sat_q31(34'd0 - sext34(mul_prod)) : mul_prod;
        endcase
    end

    assign s_axis_tready = (st_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        logic p;
        p              = pend_reg || s_axis_tuser;
        st_next        = st_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        phase_next     = phase_reg;
        env_next       = env_reg;
        pend_next      = pend_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mul_start      = 1'b0;
        mul_a          = 32'd0;
        mul_b          = 32'd0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next = s_axis_tdata;
                    case (mode_reg) inside
                        MODE_PULSE:
                        begin
                            pend_next = 1'b0;
                            y_next    = p ? Q31_MAX : 32'd0;
                            st_next   = S_DONE;
                        end
                        MODE_LIN, MODE_EXP, MODE_INV, MODE_TRI:
                        begin
                            pend_next = 1'b0;
                            if (p)
                            begin
                                phase_next = 32'd0;
                                if (mode_reg == MODE_EXP)
                                    env_next = Q31_MAX;
                                else if (mode_reg == MODE_INV)
                                    env_next = 32'd0;
                                if ((mode_reg == MODE_LIN) || (mode_reg == MODE_EXP))
                                    y_next = s_axis_tdata;
                                else
                                    y_next = 32'd0;
                                st_next = S_DONE;
                            end
                            else
                            begin
                                phase_next = phase_reg + rate_reg;
                                st_next    = S_PREP;
                            end
                        end
                        MODE_LEVEL:
                        begin
                            pend_next = p;
                            mul_start = 1'b1;
                            mul_a     = s_axis_tdata;
                            mul_b     = gain_reg;
                            st_next   = S_MOUT;
                        end
                        default:
                        begin
                            pend_next = p;
                            y_next    = 32'd0;
                            st_next   = S_DONE;
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                mul_start = 1'b1;
                case (mode_reg) inside
                    MODE_LIN:
                    begin
                        env_next = lin_env;
                        mul_a    = x_reg;
                        mul_b    = lin_env;
                        st_next  = S_MOUT;
                    end
                    MODE_EXP:
                    begin
                        mul_a   = env_reg;
                        mul_b   = lin_env;
                        st_next = S_MENV;
                    end
                    default:
                    begin
                        mul_a   = Q31_MAX;
                        mul_b   = neg_phase;
                        st_next = S_MENV;
                    end
                endcase
            end
            S_MENV:
            begin
                if (mul_done)
                    st_next = S_EUPD;
            end
            S_EUPD:
            begin
                env_next  = env_new;
                mul_start = 1'b1;
                mul_a     = x_reg;
                mul_b     = env_new;
                st_next   = S_MOUT;
            end
            S_MOUT:
            begin
                if (mul_done)
                begin
                    y_next  = mul_prod;
                    st_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = y_reg;
                    st_next        = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            phase_reg     <= 32'd0;
            env_reg       <= 32'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            env_reg       <= env_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_pulse_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (mode_reg == MODE_PULSE)) |=> (!pend_reg && (st_reg == S_DONE)))
        else $error("pulse mode left trigger pending");

    a_mul_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_busy |-> ((st_reg == S_MENV) || (st_reg == S_MOUT)))
        else $error("multiplier busy outside a multiply state");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && ((mode_reg == MODE_OFF) || (mode_reg == MODE_OFF2)))
        |=> ((y_reg == 32'd0) && (st_reg == S_DONE)))
        else $error("off mode produced a nonzero sample");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");
`endif

endmodule

@@ sv/tev_mul.sv @@
// ---------------------------------------------------------------------------
// tev_mul: bit-serial Q31 fractional multiplier
// Signed shift-add, one multiplier bit per cycle; result is the product
// shifted right by 31, floored, with -1 * -1 clamped to full scale.
// ---------------------------------------------------------------------------
module tev_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        busy,
    output logic        done,
    output logic [31:0] product
);
    import tev_pkg::*;

    logic [31:0] a_reg;
    logic [32:0] hi_reg;
    logic [31:0] lo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [33:0] addend;
    logic [33:0] sum;
    logic        last;

    assign last   = (cnt_reg == 5'd31);
    assign addend = lo_reg[0] ? sext34(a_reg) : 34'd0;
    assign sum    = last ? ({hi_reg[32], hi_reg} - addend) : ({hi_reg[32], hi_reg} + addend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[33:1];
            lo_reg <= {sum[0], lo_reg[31:1]};
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = ((hi_reg == 33'h0_4000_0000) && (lo_reg == 32'd0)) ? Q31_MAX
                   : {hi_reg[30:0], lo_reg[31]};

endmodule
